// ----- hdl/fst_pkg.sv -----
package fst_pkg;

    localparam int unsigned FLOW_W   = 24;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned COUNT_W  = 7;

    localparam int unsigned NUM_SLOTS_DEF  = 64;
    localparam int unsigned FLOW_LIMIT_DEF = 16777216;

    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLOSE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TOUCH  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SCAN   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTHING   = 3'd4;

    typedef struct packed {
        logic [FLOW_W-1:0]   flow;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

endpackage

// ----- hdl/flow_slot_table.sv -----
// flow_slot_table: open-addressed table of connection slots keyed by flow id.
// Command channel: an action is taken on a clock edge with start high and
// busy low; busy stays high until the action's last result is out.
// Result channel: result_valid marks each result beat for exactly one cycle;
// the receiver must take it then, there is no backpressure. A scan gives one
// beat per expired live slot in slot order (last on the final one), or one
// "nothing expired" beat; every other action gives one beat with last set.
// Steps: add runs two reciprocal remainder units (flow id modulo FLOW_LIMIT,
// then that result modulo NUM_SLOTS) and then probes the valid bits one slot
// at a time; lookup, close, touch and check run a remainder, a memory read
// and an update; scan reads one slot per cycle, and
// an unknown action answers on the next cycle. Busy drops in
// the cycle of the last beat, so the next command may be accepted while that
// beat is presented.
// Reset clears all valid bits and the occupied count, so every slot reads
// free at once; no clearing pass is needed.
module flow_slot_table #(
    parameter int unsigned NUM_SLOTS  = fst_pkg::NUM_SLOTS_DEF,
    parameter int unsigned FLOW_LIMIT = fst_pkg::FLOW_LIMIT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fst_pkg::ACT_W-1:0]    action,
    input  logic [fst_pkg::FLOW_W-1:0]   flow_id,
    input  logic [fst_pkg::HANDLE_W-1:0] conn_handle,
    input  logic [fst_pkg::TIME_W-1:0]   now_seconds,
    input  logic [fst_pkg::TIME_W-1:0]   deadline_seconds,
    output logic                         result_valid,
    output logic [fst_pkg::STAT_W-1:0]   status,
    output logic [fst_pkg::FLOW_W-1:0]   flow_out,
    output logic [fst_pkg::HANDLE_W-1:0] handle_out,
    output logic [fst_pkg::COUNT_W-1:0]  used_count,
    output logic                         last
);
    import fst_pkg::*;

    localparam int unsigned SW = $clog2(NUM_SLOTS);
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
    localparam logic [SW-1:0] SLOT_LAST = SW'(NUM_SLOTS - 1);
    localparam logic [SW-1:0] SLOT_ONE  = SW'(1 % NUM_SLOTS);
    localparam logic [CW-1:0] CNT_END   = CW'(NUM_SLOTS);
    localparam logic [CW-1:0] CNT_PROBE = CW'(NUM_SLOTS - 1);
    localparam logic [FLOW_W:0] FL_VAL  = (FLOW_W + 1)'(FLOW_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MODF,
        S_MODS,
        S_RD,
        S_EXEC,
        S_PROBE,
        S_SCAN,
        S_SFLUSH
    } state_t;

    state_t              state_reg;
    logic [ACT_W-1:0]    act_reg;
    logic [FLOW_W-1:0]   flow_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic [FLOW_W-1:0]   f_reg;
    logic [SW-1:0]       slot_reg;
    logic [CW-1:0]       cnt_reg;
    logic [COUNT_W-1:0]  occ_reg;
    logic                valid_reg [NUM_SLOTS];
    logic                pend_reg;
    logic [FLOW_W-1:0]   pend_flow_reg;

    logic                out_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [FLOW_W-1:0]   flow_out_reg;
    logic [HANDLE_W-1:0] handle_out_reg;
    logic [COUNT_W-1:0]  used_reg;
    logic                last_reg;

    // slot memories, registered read
    entry_t              entry_mem [NUM_SLOTS];
    logic [TIME_W-1:0]   time_mem [NUM_SLOTS];
    entry_t              entry_rd_reg;
    logic [TIME_W-1:0]   time_rd_reg;
    logic                vld_rd_reg;

    logic                accept;
    logic                rem_f_start;
    logic                rem_f_done;
    logic [FLOW_W-1:0]   rem_f;
    logic                rem_s_start;
    logic                rem_s_done;
    logic [FLOW_W-1:0]   rem_s;
    logic [FLOW_W-1:0]   rem_s_value;
    logic [FLOW_W-1:0]   f_fix;

    logic [SW-1:0]       rd_addr;
    logic                entry_we;
    logic                time_we;
    logic                live;
    logic                scan_hit;
    logic [FLOW_W:0]     f_inc;
    logic                f_wrap;
    logic [FLOW_W-1:0]   f_next;
    logic [SW-1:0]       slot_next;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    assign f_fix       = (rem_f == '0) ? FLOW_W'(1) : rem_f;
    assign rem_f_start = accept && (action == ACT_ADD);
    assign rem_s_start = (accept && (action == ACT_LOOKUP || action == ACT_CLOSE ||
                                     action == ACT_TOUCH || action == ACT_CHECK))
                         || (state_reg == S_MODF && rem_f_done);
    assign rem_s_value = (state_reg == S_IDLE) ? flow_id : f_fix;

    fst_rem #(
        .DIV (FLOW_LIMIT)
    ) u_rem_flow (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rem_f_start),
        .value (flow_id),
        .done  (rem_f_done),
        .rem   (rem_f)
    );

    fst_rem #(
        .DIV (NUM_SLOTS)
    ) u_rem_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rem_s_start),
        .value (rem_s_value),
        .done  (rem_s_done),
        .rem   (rem_s)
    );

    // next probe candidate: flow+1 mod limit, skipping zero
    always_comb
    begin
        f_inc  = {1'b0, f_reg} + 1'b1;
        f_wrap = (f_inc == FL_VAL);
        if (f_wrap)
        begin
            f_next    = FLOW_W'(1);
            slot_next = SLOT_ONE;
        end
        else
        begin
            f_next    = f_inc[FLOW_W-1:0];
            slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            rd_addr = (cnt_reg < CNT_END) ? cnt_reg[SW-1:0] : '0;
        end
        else
        begin
            rd_addr = slot_reg;
        end
    end

    assign live     = vld_rd_reg && (entry_rd_reg.flow == flow_reg);
    assign scan_hit = vld_rd_reg && (time_rd_reg < deadline_reg);
    assign entry_we = (state_reg == S_PROBE) && !valid_reg[slot_reg];
    assign time_we  = entry_we ||
                      ((state_reg == S_EXEC) && (act_reg == ACT_TOUCH) && live);

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[slot_reg] <= '{flow: f_reg, handle: handle_reg};
        end
        entry_rd_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (time_we)
        begin
            time_mem[slot_reg] <= now_reg;
        end
        time_rd_reg <= time_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= ACT_ADD;
            flow_reg       <= '0;
            handle_reg     <= '0;
            now_reg        <= '0;
            deadline_reg   <= '0;
            f_reg          <= '0;
            slot_reg       <= '0;
            cnt_reg        <= '0;
            occ_reg        <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            vld_rd_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            pend_flow_reg  <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            flow_out_reg   <= '0;
            handle_out_reg <= '0;
            used_reg       <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            vld_rd_reg     <= valid_reg[rd_addr];
            out_valid_reg  <= 1'b0;
            handle_out_reg <= '0;
            last_reg       <= 1'b1;
            used_reg       <= occ_reg;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg      <= action;
                        flow_reg     <= flow_id;
                        handle_reg   <= conn_handle;
                        now_reg      <= now_seconds;
                        deadline_reg <= deadline_seconds;
                        cnt_reg      <= '0;
                        pend_reg     <= 1'b0;
                        case (action)
                            ACT_ADD:
                            begin
                                state_reg <= S_MODF;
                            end
                            ACT_LOOKUP, ACT_CLOSE, ACT_TOUCH, ACT_CHECK:
                            begin
                                state_reg <= S_MODS;
                            end
                            ACT_SCAN:
                            begin
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                status_reg    <= ST_NOT_FOUND;
                                flow_out_reg  <= flow_id;
                            end
                        endcase
                    end
                end

                S_MODF:
                begin
                    if (rem_f_done)
                    begin
                        f_reg     <= f_fix;
                        state_reg <= S_MODS;
                    end
                end

                S_MODS:
                begin
                    if (rem_s_done)
                    begin
                        slot_reg  <= rem_s[SW-1:0];
                        state_reg <= (act_reg == ACT_ADD) ? S_PROBE : S_RD;
                    end
                end

                S_RD:
                begin
                    state_reg <= S_EXEC;
                end

                S_EXEC:
                begin
                    out_valid_reg <= 1'b1;
                    flow_out_reg  <= flow_reg;
                    status_reg    <= live ? ST_OK : ST_NOT_FOUND;
                    state_reg     <= S_IDLE;
                    case (act_reg)
                        ACT_LOOKUP:
                        begin
                            if (live)
                            begin
                                handle_out_reg <= entry_rd_reg.handle;
                            end
                        end
                        ACT_CLOSE:
                        begin
                            if (live)
                            begin
                                valid_reg[slot_reg] <= 1'b0;
                                occ_reg             <= occ_reg - 1'b1;
                                used_reg            <= occ_reg - 1'b1;
                            end
                        end
                        ACT_CHECK:
                        begin
                            if (live && (time_rd_reg < deadline_reg))
                            begin
                                status_reg <= ST_EXPIRED;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                S_PROBE:
                begin
                    if (!valid_reg[slot_reg])
                    begin
                        valid_reg[slot_reg] <= 1'b1;
                        occ_reg             <= occ_reg + 1'b1;
                        used_reg            <= occ_reg + 1'b1;
                        out_valid_reg       <= 1'b1;
                        status_reg          <= ST_OK;
                        flow_out_reg        <= f_reg;
                        state_reg           <= S_IDLE;
                    end
                    else if (cnt_reg == CNT_PROBE)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_FULL;
                        flow_out_reg  <= flow_reg;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        f_reg    <= f_next;
                        slot_reg <= slot_next;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end

                S_SCAN:
                begin
                    // data for slot cnt-1 arrives now; hold one hit back so
                    // the final one can carry last
                    cnt_reg <= cnt_reg + 1'b1;
                    if ((cnt_reg != '0) && scan_hit)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            status_reg    <= ST_EXPIRED;
                            flow_out_reg  <= pend_flow_reg;
                            last_reg      <= 1'b0;
                        end
                        pend_reg      <= 1'b1;
                        pend_flow_reg <= entry_rd_reg.flow;
                    end
                    if (cnt_reg == CNT_END)
                    begin
                        state_reg <= S_SFLUSH;
                    end
                end

                S_SFLUSH:
                begin
                    out_valid_reg <= 1'b1;
                    if (pend_reg)
                    begin
                        status_reg   <= ST_EXPIRED;
                        flow_out_reg <= pend_flow_reg;
                    end
                    else
                    begin
                        status_reg   <= ST_NOTHING;
                        flow_out_reg <= flow_reg;
                    end
                    pend_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign flow_out     = flow_out_reg;
    assign handle_out   = handle_out_reg;
    assign used_count   = used_reg;
    assign last         = last_reg;

endmodule

// ----- hdl/fst_rem.sv -----
module fst_rem #(
    parameter int unsigned DIV = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fst_pkg::FLOW_W-1:0] value,
    output logic                       done,
    output logic [fst_pkg::FLOW_W-1:0] rem
);
    import fst_pkg::*;

    // floor(2^FLOW_W / DIV) leaves the quotient estimate at most one short,
    // so a single compare and subtract finishes the remainder
    localparam int unsigned MW = FLOW_W + 1;
    localparam int unsigned PW = FLOW_W + MW;
    localparam logic [MW-1:0] RECIP   = MW'((64'd1 << FLOW_W) / DIV);
    localparam logic [MW-1:0] DIV_VAL = MW'(DIV);

    logic [FLOW_W-1:0] value_reg;
    logic [FLOW_W-1:0] quot_reg;
    logic [FLOW_W-1:0] part_reg;
    logic [FLOW_W-1:0] rem_reg;
    logic              stage1_reg;
    logic              stage2_reg;
    logic              done_reg;
    logic [PW-1:0]     prod;
    logic [FLOW_W-1:0] back;
    logic [MW-1:0]     part_ext;
    logic [MW-1:0]     rem_next;

    // quotient * DIV never exceeds value, so the low bits are exact
    always_comb
    begin
        prod     = PW'(value) * PW'(RECIP);
        back     = quot_reg * DIV_VAL[FLOW_W-1:0];
        part_ext = {1'b0, part_reg};
        rem_next = (part_ext >= DIV_VAL) ? part_ext - DIV_VAL : part_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg  <= '0;
            quot_reg   <= '0;
            part_reg   <= '0;
            rem_reg    <= '0;
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            stage2_reg <= stage1_reg;
            done_reg   <= stage2_reg;
            if (start)
            begin
                value_reg <= value;
                quot_reg  <= prod[FLOW_W +: FLOW_W];
            end
            if (stage1_reg)
            begin
                part_reg <= value_reg - back;
            end
            if (stage2_reg)
            begin
                rem_reg <= rem_next[FLOW_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import fst_pkg::*;

    localparam int unsigned NSLOT       = NUM_SLOTS_DEF;
    localparam int unsigned FLOW_LIMIT  = FLOW_LIMIT_DEF;
    localparam int unsigned DRAIN_WAIT  = 200;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Action codes the block does not define; they must answer "not found".
    localparam logic [ACT_W-1:0] ACT_UNUSED_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_B = 3'd7;

    typedef struct {
        logic [STAT_W-1:0]   status;
        logic [FLOW_W-1:0]   flow;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  used;
        logic                last;
    } table_reply_t;

    logic                clk;
    logic                rst_n            = 1'b0;
    logic                start            = 1'b0;
    logic [ACT_W-1:0]    action           = '0;
    logic [FLOW_W-1:0]   flow_id          = '0;
    logic [HANDLE_W-1:0] conn_handle      = '0;
    logic [TIME_W-1:0]   now_seconds      = '0;
    logic [TIME_W-1:0]   deadline_seconds = '0;
    logic                busy;
    logic                result_valid;
    logic [STAT_W-1:0]   status;
    logic [FLOW_W-1:0]   flow_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [COUNT_W-1:0]  used_count;
    logic                last;

    // Shadow copy of the slot table
    logic [FLOW_W-1:0]   shadow_flow   [NSLOT];
    logic [HANDLE_W-1:0] shadow_handle [NSLOT];
    logic [TIME_W-1:0]   shadow_atime  [NSLOT];
    logic [COUNT_W-1:0]  shadow_used;

    table_reply_t pending_replies[$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;
    bit           gaps_on     = 1'b1;
    int unsigned  wall_seconds;

    flow_slot_table u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .flow_id          (flow_id),
        .conn_handle      (conn_handle),
        .now_seconds      (now_seconds),
        .deadline_seconds (deadline_seconds),
        .result_valid     (result_valid),
        .status           (status),
        .flow_out         (flow_out),
        .handle_out       (handle_out),
        .used_count       (used_count),
        .last             (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    task automatic push_reply(input logic [STAT_W-1:0] st, input logic [FLOW_W-1:0] fl,
                              input logic [HANDLE_W-1:0] hd, input logic lst);
        table_reply_t r;
        r.status = st;
        r.flow   = fl;
        r.handle = hd;
        r.used   = shadow_used;
        r.last   = lst;
        pending_replies.insert(pending_replies.size(), r);
    endtask

    function automatic bit flow_is_live(input logic [FLOW_W-1:0] fl);
        return fl != '0 && shadow_flow[fl % NSLOT] == fl;
    endfunction

    // Update the shadow table for one accepted command and queue its replies.
    task automatic predict_table_replies(input logic [ACT_W-1:0] act,
                                         input logic [FLOW_W-1:0] fl,
                                         input logic [HANDLE_W-1:0] hd,
                                         input logic [TIME_W-1:0] nw,
                                         input logic [TIME_W-1:0] dl);
        int unsigned f;
        int unsigned slot;
        int unsigned home;
        int unsigned hits;
        int unsigned k;
        bit          found;
        home = fl % NSLOT;
        case (act)
            ACT_ADD:
            begin
                f = fl % FLOW_LIMIT;
                if (f == 0)
                    f = 1;
                slot  = f % NSLOT;
                found = shadow_flow[slot] == '0;
                // linear probe over flow ids; flow 0 is skipped on wrap
                for (int i = 1; i < NSLOT && !found; i++)
                begin
                    f = (f + 1) % FLOW_LIMIT;
                    if (f == 0)
                        f = 1;
                    slot  = f % NSLOT;
                    found = shadow_flow[slot] == '0;
                end
                if (!found)
                    push_reply(ST_FULL, fl, '0, 1'b1);
                else
                begin
                    shadow_flow[slot]   = f[FLOW_W-1:0];
                    shadow_handle[slot] = hd;
                    shadow_atime[slot]  = nw;
                    shadow_used         = shadow_used + 1'b1;
                    push_reply(ST_OK, f[FLOW_W-1:0], '0, 1'b1);
                end
            end
            ACT_LOOKUP:
            begin
                if (flow_is_live(fl))
                    push_reply(ST_OK, fl, shadow_handle[home], 1'b1);
                else
                    push_reply(ST_NOT_FOUND, fl, '0, 1'b1);
            end
            ACT_CLOSE:
            begin
                if (flow_is_live(fl))
                begin
                    shadow_flow[home]  = '0;
                    shadow_atime[home] = '0;
                    shadow_used        = shadow_used - 1'b1;
                    push_reply(ST_OK, fl, '0, 1'b1);
                end
                else
                    push_reply(ST_NOT_FOUND, fl, '0, 1'b1);
            end
            ACT_TOUCH:
            begin
                if (flow_is_live(fl))
                begin
                    shadow_atime[home] = nw;
                    push_reply(ST_OK, fl, '0, 1'b1);
                end
                else
                    push_reply(ST_NOT_FOUND, fl, '0, 1'b1);
            end
            ACT_CHECK:
            begin
                if (!flow_is_live(fl))
                    push_reply(ST_NOT_FOUND, fl, '0, 1'b1);
                else if (shadow_atime[home] < dl)
                    push_reply(ST_EXPIRED, fl, '0, 1'b1);
                else
                    push_reply(ST_OK, fl, '0, 1'b1);
            end
            ACT_SCAN:
            begin
                hits = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (shadow_flow[i] != '0 && shadow_atime[i] < dl)
                        hits++;
                if (hits == 0)
                    push_reply(ST_NOTHING, fl, '0, 1'b1);
                else
                begin
                    k = 0;
                    for (int i = 0; i < NSLOT; i++)
                        if (shadow_flow[i] != '0 && shadow_atime[i] < dl)
                        begin
                            k++;
                            push_reply(ST_EXPIRED, shadow_flow[i], '0, k == hits);
                        end
                end
            end
            default:
                push_reply(ST_NOT_FOUND, fl, '0, 1'b1);
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : reply_check
        table_reply_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected reply, expected none, got status %0d flow 0x%0h",
                         $time, status, flow_out);
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("flow_out", 32'(want.flow), 32'(flow_out));
                check_field("handle_out", 32'(want.handle), 32'(handle_out));
                check_field("used_count", 32'(want.used), 32'(used_count));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    // One command beat; start is left high so the next beat can follow back to back.
    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [FLOW_W-1:0] fl,
                            input logic [HANDLE_W-1:0] hd, input logic [TIME_W-1:0] nw,
                            input logic [TIME_W-1:0] dl);
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start            <= 1'b1;
        action           <= act;
        flow_id          <= fl;
        conn_handle      <= hd;
        now_seconds      <= nw;
        deadline_seconds <= dl;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_table_replies(act, fl, hd, nw, dl);
    endtask

    // Mostly live flows, plus slot aliases, flow zero and random ids.
    function automatic logic [FLOW_W-1:0] pick_flow();
        int unsigned live_slots[$];
        int unsigned r;
        logic [FLOW_W-1:0] fl;
        for (int i = 0; i < NSLOT; i++)
            if (shadow_flow[i] != '0)
                live_slots.insert(live_slots.size(), i);
        r  = $urandom_range(0, 99);
        fl = FLOW_W'($urandom());
        if (live_slots.size() != 0 && r < 75)
        begin
            fl = shadow_flow[live_slots[$urandom_range(0, live_slots.size() - 1)]];
            if (r >= 60)
                fl = fl ^ (FLOW_W'($urandom_range(1, 262143)) << 6);
        end
        else if (r < 85)
            fl = '0;
        return fl;
    endfunction

    task automatic send_random_cmd();
        int unsigned       r;
        logic [ACT_W-1:0]  act;
        logic [FLOW_W-1:0] fl;
        logic [TIME_W-1:0] nw;
        logic [TIME_W-1:0] dl;
        r = $urandom_range(0, 99);
        if (r < 30)
            act = ACT_ADD;
        else if (r < 44)
            act = ACT_LOOKUP;
        else if (r < 56)
            act = ACT_CLOSE;
        else if (r < 68)
            act = ACT_TOUCH;
        else if (r < 83)
            act = ACT_CHECK;
        else if (r < 94)
            act = ACT_SCAN;
        else if (r < 97)
            act = ACT_UNUSED_A;
        else
            act = ACT_UNUSED_B;

        if (act == ACT_ADD)
        begin
            r = $urandom_range(0, 7);
            if (r < 4)
                fl = FLOW_W'($urandom());
            else if (r < 6)
                fl = FLOW_W'($urandom_range(0, 255));
            else if (r < 7)
                fl = '0;
            else
                fl = FLOW_W'(24'hFFFFC0 + $urandom_range(0, 63));
        end
        else
            fl = pick_flow();

        wall_seconds += $urandom_range(0, 4);
        nw = ($urandom_range(0, 7) == 0) ? $urandom() : wall_seconds;
        r  = $urandom_range(0, 9);
        if (r == 0)
            dl = '0;
        else if (r == 1)
            dl = '1;
        else if (r == 2)
            dl = $urandom();
        else
            dl = wall_seconds - $urandom_range(0, 40);
        send_cmd(act, fl, HANDLE_W'($urandom()), nw, dl);
    endtask

    task automatic test_directed();
        send_cmd(ACT_ADD, 24'h000000, 16'h0000, 32'd0, 32'd0);          // hint zero -> 1
        send_cmd(ACT_ADD, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(ACT_ADD, 24'h000041, 16'h1234, 32'd100, 32'd0);        // collides, probes
        send_cmd(ACT_ADD, 24'hFFFFFF, 16'hA5A5, 32'd200, 32'd0);        // probe wraps past 0
        send_cmd(ACT_LOOKUP, 24'h000001, 16'h0000, 32'd0, 32'd0);
        send_cmd(ACT_LOOKUP, 24'hFFFFFF, 16'h0000, 32'd0, 32'd0);
        send_cmd(ACT_LOOKUP, 24'h000000, 16'hFFFF, 32'd0, 32'd0);
        send_cmd(ACT_LOOKUP, 24'h000041, 16'h0000, 32'd0, 32'd0);       // same slot, other flow
        send_cmd(ACT_TOUCH, 24'hFFFFFF, 16'h0000, 32'd5, 32'd0);
        send_cmd(ACT_TOUCH, 24'h000000, 16'h0000, 32'd7, 32'd0);
        send_cmd(ACT_CHECK, 24'hFFFFFF, 16'h0000, 32'd0, 32'd5);        // equal: not expired
        send_cmd(ACT_CHECK, 24'hFFFFFF, 16'h0000, 32'd0, 32'd6);
        send_cmd(ACT_CHECK, 24'h000000, 16'h0000, 32'd0, 32'hFFFF_FFFF);
        send_cmd(ACT_SCAN, 24'hABCDEF, 16'h0000, 32'd0, 32'd0);         // nothing expired
        send_cmd(ACT_SCAN, 24'h000000, 16'h0000, 32'd0, 32'hFFFF_FFFF);
        send_cmd(ACT_SCAN, 24'h000000, 16'h0000, 32'd0, 32'd101);
        send_cmd(ACT_CLOSE, 24'h000042, 16'h0000, 32'd0, 32'd0);
        send_cmd(ACT_CLOSE, 24'h000042, 16'h0000, 32'd0, 32'd0);
        send_cmd(ACT_CLOSE, 24'h000000, 16'h0000, 32'd0, 32'd0);
        send_cmd(ACT_UNUSED_A, 24'h123456, 16'h5555, 32'd0, 32'd0);
        send_cmd(ACT_UNUSED_B, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fill every slot, hit the full case, scan, then send 40 closes to drain part of the table.
    task automatic test_fill_and_full();
        int unsigned guard;
        guard = 0;
        while (shadow_used < NSLOT && guard < 150)
        begin
            wall_seconds += $urandom_range(0, 3);
            send_cmd(ACT_ADD, FLOW_W'($urandom()), HANDLE_W'($urandom()), wall_seconds, '0);
            guard++;
        end
        send_cmd(ACT_ADD, FLOW_W'($urandom()), HANDLE_W'($urandom()), wall_seconds, '0);
        send_cmd(ACT_ADD, 24'h000000, 16'hFFFF, wall_seconds, '0);
        // only slot 0 free: a probe from the top wraps past it and reports full
        send_cmd(ACT_CLOSE, shadow_flow[0], '0, '0, '0);
        send_cmd(ACT_ADD, 24'hFFFFFF, HANDLE_W'($urandom()), wall_seconds, '0);
        send_cmd(ACT_ADD, 24'h000000, HANDLE_W'($urandom()), wall_seconds, '0);
        send_cmd(ACT_SCAN, FLOW_W'($urandom()), '0, '0, 32'hFFFF_FFFF);
        send_cmd(ACT_SCAN, FLOW_W'($urandom()), '0, '0, wall_seconds - 40);
        repeat (40)
            send_cmd(ACT_CLOSE, pick_flow(), '0, '0, '0);
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 130; i++)
        begin
            if (i % 30 == 0)
                gaps_on = $urandom_range(0, 2) != 0;
            send_random_cmd();
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (40)
            send_random_cmd();
        start <= 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            shadow_flow[i]   = '0;
            shadow_handle[i] = '0;
            shadow_atime[i]  = '0;
        end
        shadow_used  = '0;
        wall_seconds = $urandom();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_full();
        test_random_mix();
        test_back_to_back();

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/fst_pkg.sv
hdl/fst_rem.sv
hdl/flow_slot_table.sv
tb/testbench.sv
